[design/primality_test_32bit_assert.svh]
// Assertion macros shared by the primality tester checker.
`ifndef PRIMALITY_TEST_32BIT_ASSERT_SVH
`define PRIMALITY_TEST_32BIT_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define PT32_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define PT32_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pt32_pkg.sv]
// Shared types and constants of the 32-bit primality tester.
package pt32_pkg;

  // Datapath width; the candidate is masked to this many bits.
  localparam int NUM_BITS  = 32;
  localparam int CNT_W     = $clog2(NUM_BITS);
  localparam int NUM_TRIAL = 10;
  localparam int NUM_BASES = 3;
  localparam int BASE_IDX_W = $clog2(NUM_BASES);

  typedef logic [NUM_BITS-1:0] word_t;
  typedef logic [NUM_BITS+1:0] ext_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [4:0]          prime_t;
  typedef logic [5:0]          base_t;

  // Small primes used for trial division.
  localparam prime_t TRIAL_PRIMES [NUM_TRIAL] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
  };

  // Witness bases, exact for every 32-bit candidate.
  localparam base_t MR_BASES [NUM_BASES] = '{6'd2, 6'd7, 6'd61};

  // Request to the modular multiplier.
  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } mul_req_t;

  // Answer of the modular multiplier.
  typedef struct packed {
    logic  done;
    word_t product;
  } mul_res_t;

  // Answer of the trial divider.
  typedef struct packed {
    logic done;
    logic divisible;
  } trial_res_t;

endpackage

[design/pt32_trial.sv]
// Bit-serial trial division of the candidate by the ten small primes.
module pt32_trial (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pt32_pkg::word_t       value_i,
  output pt32_pkg::trial_res_t  res_o
);

  pt32_pkg::word_t sh_q, sh_d;
  pt32_pkg::cnt_t  cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  pt32_pkg::prime_t rem_q [pt32_pkg::NUM_TRIAL];
  pt32_pkg::prime_t rem_d [pt32_pkg::NUM_TRIAL];
  logic [5:0]       twice [pt32_pkg::NUM_TRIAL];
  logic             any_zero;

  // One candidate bit per cycle, most significant first, into every lane.
  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    for (int k = 0; k < pt32_pkg::NUM_TRIAL; k++) begin
      twice[k] = {rem_q[k], sh_q[pt32_pkg::NUM_BITS-1]};
      rem_d[k] = rem_q[k];
    end
    if (start_i) begin
      sh_d  = value_i;
      cnt_d = pt32_pkg::cnt_t'(pt32_pkg::NUM_BITS - 1);
      run_d = 1'b1;
      for (int k = 0; k < pt32_pkg::NUM_TRIAL; k++) begin
        rem_d[k] = '0;
      end
    end else if (run_q) begin
      sh_d = {sh_q[pt32_pkg::NUM_BITS-2:0], 1'b0};
      for (int k = 0; k < pt32_pkg::NUM_TRIAL; k++) begin
        if (twice[k] >= {1'b0, pt32_pkg::TRIAL_PRIMES[k]}) begin
          rem_d[k] = pt32_pkg::prime_t'(twice[k] - {1'b0, pt32_pkg::TRIAL_PRIMES[k]});
        end else begin
          rem_d[k] = twice[k][4:0];
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // A lane whose remainder is zero divides the candidate.
  always_comb begin
    any_zero = 1'b0;
    for (int k = 0; k < pt32_pkg::NUM_TRIAL; k++) begin
      any_zero = any_zero | (rem_q[k] == '0);
    end
  end

  assign res_o.done      = done_q;
  assign res_o.divisible = any_zero;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

endmodule

[design/pt32_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module pt32_mulmod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pt32_pkg::mul_req_t  req_i,
  input  pt32_pkg::word_t     modulus_i,
  output pt32_pkg::mul_res_t  res_o
);

  pt32_pkg::word_t a_q, a_d;
  pt32_pkg::word_t b_q, b_d;
  pt32_pkg::word_t acc_q, acc_d;
  pt32_pkg::cnt_t  cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  pt32_pkg::ext_t  sum, mod1, mod2;

  // acc = 2*acc + bit*a, then bring it back below the modulus (sum < 3n).
  assign mod1 = pt32_pkg::ext_t'(modulus_i);
  assign mod2 = pt32_pkg::ext_t'({modulus_i, 1'b0});
  assign sum  = pt32_pkg::ext_t'({acc_q, 1'b0})
              + (b_q[pt32_pkg::NUM_BITS-1] ? pt32_pkg::ext_t'(a_q) : '0);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d   = req_i.op_a;
      b_d   = req_i.op_b;
      acc_d = '0;
      cnt_d = pt32_pkg::cnt_t'(pt32_pkg::NUM_BITS - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      if (sum >= mod2) begin
        acc_d = pt32_pkg::word_t'(sum - mod2);
      end else if (sum >= mod1) begin
        acc_d = pt32_pkg::word_t'(sum - mod1);
      end else begin
        acc_d = pt32_pkg::word_t'(sum);
      end
      b_d   = {b_q[pt32_pkg::NUM_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign res_o.done    = done_q;
  assign res_o.product = acc_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

endmodule

[design/primality_test_32bit.sv]
// Top level of the deterministic 32-bit primality tester.
// Pulse start while busy is low to hand over one candidate; busy stays high
// until the answer, which appears on is_prime_o for exactly one cycle with
// done_o high, and busy drops in that same cycle so a new start may follow.
// The answer cannot be held off, so capture it when done_o is seen. Trial
// division by the primes 2 to 29 comes first; a candidate below two or with
// a small factor is answered right after it; otherwise the powers of two
// are split off n-1, and three witness rounds run on one shared bit-serial
// modular multiplier. A round squares the base once per exponent bit but the
// top one, multiplies once per set bit, and then takes up to r-1 squarings.
module primality_test_32bit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [31:0] candidate_i,
  output logic        busy,
  output logic        done_o,
  output logic        is_prime_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_TRIAL    = 10'b00_0000_0010,
    S_DECOMP   = 10'b00_0000_0100,
    S_LOAD     = 10'b00_0000_1000,
    S_POW      = 10'b00_0001_0000,
    S_MUL_ACC  = 10'b00_0010_0000,
    S_MUL_BASE = 10'b00_0100_0000,
    S_CHECK    = 10'b00_1000_0000,
    S_SQ       = 10'b01_0000_0000,
    S_SQ_WAIT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  pt32_pkg::word_t n_q, n_d;
  pt32_pkg::word_t d_q, d_d;
  pt32_pkg::word_t expo_q, expo_d;
  pt32_pkg::word_t acc_q, acc_d;
  pt32_pkg::word_t base_q, base_d;
  pt32_pkg::cnt_t  r_q, r_d;
  pt32_pkg::cnt_t  sq_q, sq_d;
  logic [pt32_pkg::BASE_IDX_W-1:0] k_q, k_d;
  logic            done_q, done_d;
  logic            prime_q, prime_d;

  pt32_pkg::mul_req_t   mul_req;
  pt32_pkg::mul_res_t   mul_res;
  pt32_pkg::trial_res_t trial_res;
  logic                 trial_start;
  logic                 accept;
  logic                 small_prime;
  pt32_pkg::word_t      n_minus_1;
  pt32_pkg::word_t      witness;

  assign accept      = start && (state_q == S_IDLE);
  assign trial_start = accept;
  assign n_minus_1   = n_q - 1'b1;
  assign witness     = pt32_pkg::word_t'(pt32_pkg::MR_BASES[k_q]);

  // Candidate equal to one of the trial primes.
  always_comb begin
    small_prime = 1'b0;
    for (int k = 0; k < pt32_pkg::NUM_TRIAL; k++) begin
      small_prime = small_prime |
                    (n_q == pt32_pkg::word_t'(pt32_pkg::TRIAL_PRIMES[k]));
    end
  end

  pt32_trial u_trial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trial_start),
    .value_i (candidate_i[pt32_pkg::NUM_BITS-1:0]),
    .res_o   (trial_res)
  );

  pt32_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .modulus_i (n_q),
    .res_o     (mul_res)
  );

  // Sequencer: trial division, split of n-1, then the witness rounds.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    d_d     = d_q;
    expo_d  = expo_q;
    acc_d   = acc_q;
    base_d  = base_q;
    r_d     = r_q;
    sq_d    = sq_q;
    k_d     = k_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    mul_req = '{start: 1'b0, op_a: acc_q, op_b: base_q};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          n_d     = candidate_i[pt32_pkg::NUM_BITS-1:0];
          state_d = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (trial_res.done) begin
          if (trial_res.divisible || (n_q < pt32_pkg::word_t'(2))) begin
            prime_d = small_prime;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            d_d     = n_minus_1;
            r_d     = '0;
            state_d = S_DECOMP;
          end
        end
      end
      S_DECOMP: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[pt32_pkg::NUM_BITS-1:1]};
          r_d = r_q + 1'b1;
        end else begin
          k_d     = '0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // Candidate is at least 31 here, so one subtraction reduces the base.
        base_d  = (witness >= n_q) ? witness - n_q : witness;
        acc_d   = pt32_pkg::word_t'(1);
        expo_d  = d_q;
        state_d = S_POW;
      end
      S_POW: begin
        if (expo_q == '0) begin
          state_d = S_CHECK;
        end else if (expo_q[0]) begin
          mul_req = '{start: 1'b1, op_a: acc_q, op_b: base_q};
          state_d = S_MUL_ACC;
        end else begin
          mul_req = '{start: 1'b1, op_a: base_q, op_b: base_q};
          state_d = S_MUL_BASE;
        end
      end
      S_MUL_ACC: begin
        if (mul_res.done) begin
          acc_d = mul_res.product;
          if (expo_q[pt32_pkg::NUM_BITS-1:1] == '0) begin
            expo_d  = '0;
            state_d = S_POW;
          end else begin
            mul_req = '{start: 1'b1, op_a: base_q, op_b: base_q};
            state_d = S_MUL_BASE;
          end
        end
      end
      S_MUL_BASE: begin
        if (mul_res.done) begin
          base_d  = mul_res.product;
          expo_d  = {1'b0, expo_q[pt32_pkg::NUM_BITS-1:1]};
          state_d = S_POW;
        end
      end
      S_CHECK: begin
        if ((acc_q <= pt32_pkg::word_t'(1)) || (acc_q == n_minus_1)) begin
          if (k_q == pt32_pkg::BASE_IDX_W'(pt32_pkg::NUM_BASES - 1)) begin
            prime_d = 1'b1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_LOAD;
          end
        end else begin
          sq_d    = r_q - 1'b1;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (acc_q == n_minus_1) begin
          if (k_q == pt32_pkg::BASE_IDX_W'(pt32_pkg::NUM_BASES - 1)) begin
            prime_d = 1'b1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_LOAD;
          end
        end else if (sq_q == '0) begin
          prime_d = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mul_req = '{start: 1'b1, op_a: acc_q, op_b: acc_q};
          sq_d    = sq_q - 1'b1;
          state_d = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (mul_res.done) begin
          acc_d   = mul_res.product;
          state_d = S_SQ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
      r_q     <= '0;
      sq_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      k_q     <= k_d;
      r_q     <= r_d;
      sq_q    <= sq_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    expo_q  <= expo_d;
    acc_q   <= acc_d;
    base_q  <= base_d;
    prime_q <= prime_d;
  end

endmodule

[design/pt32_checker.sv]
// Port-level checker for the primality tester, bound to the top level.
`include "primality_test_32bit_assert.svh"

module pt32_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  `PT32_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `PT32_ASSERT_NOW(a_done_idle, done_o, !busy, "result beat while still busy")
  `PT32_ASSERT_NOW(a_busy_end, $fell(busy), done_o, "busy dropped without a result beat")
  `PT32_ASSERT_NEXT(a_done_single, done_o, !done_o, "result beat lasted more than a cycle")

endmodule

bind primality_test_32bit pt32_checker u_pt32_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

[tb/testbench.sv]
// Self-checking testbench for the 32-bit primality tester: directed table, then random candidates.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run length and timing limits.
  localparam int NUM_RANDOM   = 76;
  localparam int CALM_TAIL    = 20;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Where a directed row takes its expected verdict from.
  typedef enum logic {
    FROM_MODEL,
    TYPED_IN
  } verdict_src_e;

  typedef struct packed {
    logic [31:0]  number;
    verdict_src_e src;
    logic         verdict;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] number;
    logic        verdict;
  } pending_verdict_t;

  // Trial divisors and witness bases, kept separate from the design's own copies.
  localparam longint unsigned SMALL_PRIMES [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
  localparam longint unsigned WITNESSES [3] = '{2, 7, 61};

  localparam int NUM_DIRECTED = 24;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'd0,          TYPED_IN,   1'b0},  // below two
    '{32'd1,          TYPED_IN,   1'b0},
    '{32'd2,          TYPED_IN,   1'b1},  // equals a trial prime
    '{32'd3,          TYPED_IN,   1'b1},
    '{32'd7,          TYPED_IN,   1'b1},
    '{32'd29,         TYPED_IN,   1'b1},  // largest trial prime
    '{32'd4,          TYPED_IN,   1'b0},
    '{32'd30,         TYPED_IN,   1'b0},
    '{32'd49,         TYPED_IN,   1'b0},
    '{32'd31,         FROM_MODEL, 1'b0},  // first value past trial division
    '{32'd61,         TYPED_IN,   1'b1},  // witness base reduces to zero
    '{32'd841,        TYPED_IN,   1'b0},  // 29 squared
    '{32'd961,        FROM_MODEL, 1'b0},  // 31 squared
    '{32'd2047,       FROM_MODEL, 1'b0},  // strong pseudoprime to base 2
    '{32'd1373653,    FROM_MODEL, 1'b0},
    '{32'd25326001,   FROM_MODEL, 1'b0},
    '{32'd3215031751, FROM_MODEL, 1'b0},
    '{32'd65537,      FROM_MODEL, 1'b0},
    '{32'd2147483647, FROM_MODEL, 1'b0},
    '{32'h8000_0000,  TYPED_IN,   1'b0},
    '{32'h5555_5555,  FROM_MODEL, 1'b0},
    '{32'hFFFF_FFFB,  FROM_MODEL, 1'b0},  // largest 32-bit prime
    '{32'hFFFF_FFFE,  TYPED_IN,   1'b0},
    '{32'hFFFF_FFFF,  TYPED_IN,   1'b0}   // all ones, divisible by 3
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic [31:0] candidate_i;
  logic        busy;
  logic        done_o;
  logic        is_prime_o;

  pending_verdict_t pending_verdicts [$];
  int unsigned      failures;
  int unsigned      cycle_count;

  primality_test_32bit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .candidate_i(candidate_i),
    .busy       (busy),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  // Clock generation, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Trial division, then strong-probable-prime rounds for each witness base.
  function automatic logic primality_of(input logic [31:0] value);
    longint unsigned n;
    longint unsigned odd_part;
    longint unsigned x;
    longint unsigned b;
    longint unsigned e;
    int unsigned     twos;
    int unsigned     i;
    n = value;
    if (n < 2) return 1'b0;
    foreach (SMALL_PRIMES[k]) begin
      if (n % SMALL_PRIMES[k] == 0) return n == SMALL_PRIMES[k];
    end
    odd_part = n - 1;
    twos = 0;
    while (odd_part[0] == 1'b0) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    foreach (WITNESSES[k]) begin
      // Square-and-multiply power of the base.
      b = WITNESSES[k] % n;
      e = odd_part;
      x = 1;
      while (e != 0) begin
        if (e[0]) x = (x * b) % n;
        e = e >> 1;
        b = (b * b) % n;
      end
      if (x <= 1 || x == n - 1) continue;
      for (i = 0; i + 1 < twos && x != n - 1; i++) begin
        x = (x * x) % n;
      end
      if (x != n - 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Draw a random candidate; most are chosen so the witness rounds actually run.
  function automatic logic [31:0] random_candidate();
    logic [31:0] value;
    logic        has_factor;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      value = $urandom();
    end else if (kind < 40) begin
      value = $urandom_range(0, 1023);
    end else if (kind < 75) begin
      // Odd and free of small factors, mostly composite.
      do begin
        value = $urandom();
        has_factor = 1'b0;
        foreach (SMALL_PRIMES[k]) begin
          if (value % SMALL_PRIMES[k] == 0) has_factor = 1'b1;
        end
      end while (has_factor);
    end else begin
      do begin
        value = $urandom() | 32'd1;
      end while (!primality_of(value));
    end
    return value;
  endfunction

  // Hand one candidate over and record its expected verdict once the beat is taken.
  task automatic send_candidate(input logic [31:0] value, input logic verdict, input int gap);
    pending_verdict_t entry;
    start       <= 1'b1;
    candidate_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    entry.number  = value;
    entry.verdict = verdict;
    pending_verdicts.insert(pending_verdicts.size(), entry);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Idle gap drawn at random, or none at all.
  function automatic int random_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
  endfunction

  // Stimulus: reset, directed table, random candidates, then drain.
  initial begin
    logic [31:0] value;
    logic        verdict;
    failures    = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    candidate_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[k]) begin
      value = DIRECTED_ROWS[k].number;
      verdict = (DIRECTED_ROWS[k].src == TYPED_IN) ? DIRECTED_ROWS[k].verdict
                                                    : primality_of(value);
      send_candidate(value, verdict, random_gap());
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      value = random_candidate();
      send_candidate(value, primality_of(value), (i < NUM_RANDOM - CALM_TAIL) ? random_gap() : 0);
    end
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result checker: every done beat must match the oldest pending verdict.
  always @(posedge clk_i) begin
    pending_verdict_t want;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result beat: is_prime actual %b", is_prime_o);
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        if (is_prime_o !== want.verdict) begin
          $error("is_prime mismatch for candidate %0d: expected %b, actual %b",
                 want.number, want.verdict, is_prime_o);
          failures++;
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end
  initial cycle_count = 0;

endmodule
